// File: src/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types, character codes and decimal digit tables for the fixed-point
// 8.8 to decimal text unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fqd_pkg;

  // number of character cells, one per written position at most
  localparam int unsigned NUM_CELLS = 10;

  // configuration register indexes
  localparam logic REG_INT_WIDTH   = 1'b0;
  localparam logic REG_FRAC_DIGITS = 1'b1;

  // configuration reset values
  localparam logic [3:0] INT_WIDTH_RST   = 4'd4;
  localparam logic [2:0] FRAC_DIGITS_RST = 3'd2;

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // one character held in a cell
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [6:0] code;
  } chr_t;

  localparam chr_t CHR_EMPTY = '{valid: 1'b0, last: 1'b0, code: CHAR_ZERO};

  typedef logic [11:0] int_bcd_tab_t [256];
  typedef logic [15:0] frac_bcd_tab_t [256];

  // three bcd digits of the integer byte
  function automatic int_bcd_tab_t build_int_bcd();
    int_bcd_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = {4'((i / 100) % 10), 4'((i / 10) % 10), 4'(i % 10)};
    end
    return t;
  endfunction

  // four bcd digits of the scaled fraction byte, 39*low + low/16
  function automatic frac_bcd_tab_t build_frac_bcd();
    frac_bcd_tab_t t;
    int            f;
    for (int i = 0; i < 256; i++) begin
      f    = 39 * i + (i / 16);
      t[i] = {4'((f / 1000) % 10), 4'((f / 100) % 10), 4'((f / 10) % 10), 4'(f % 10)};
    end
    return t;
  endfunction

  localparam int_bcd_tab_t  INT_BCD  = build_int_bcd();
  localparam frac_bcd_tab_t FRAC_BCD = build_frac_bcd();

  // ascii code of one decimal digit
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO | {3'b000, d};
  endfunction

endpackage

`default_nettype wire

// File: src/fqd_layout.sv
// ----------------------------------------------------------------------------
// fqd_layout
// Turns one fixed-point value into the packed list of written positions and
// characters that is loaded into the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_layout #(
  parameter int unsigned MAX_INT_WIDTH = 8,
  parameter int unsigned POS_W         = 4
) (
  input  logic signed [15:0] fixed_value_i,
  input  logic [3:0]         int_width_i,
  input  logic [2:0]         frac_digits_i,
  output logic [POS_W-1:0]   pos_o [fqd_pkg::NUM_CELLS],
  output fqd_pkg::chr_t      chr_o [fqd_pkg::NUM_CELLS]
);

  localparam int unsigned CW = (POS_W > 4) ? POS_W : 4;

  logic             neg;
  logic [15:0]      mag_val;
  logic [7:0]       hi;
  logic [7:0]       lo;
  logic [11:0]      int_bcd;
  logic [15:0]      frac_bcd;
  logic             int_neg;
  logic [1:0]       ndig;
  logic [2:0]       len;
  logic [2:0]       n;
  logic [2:0]       fd;
  logic [POS_W-1:0] w;
  logic [POS_W-1:0] base;
  logic             lead;
  logic [CW-1:0]    iw_ext;
  logic [6:0]       text [4];
  logic [3:0]       fdig [4];

  // magnitude and digit lookup
  always_comb begin
    neg      = fixed_value_i[15];
    mag_val  = neg ? (~fixed_value_i + 16'd1) : fixed_value_i;
    hi       = mag_val[15:8];
    lo       = mag_val[7:0];
    int_bcd  = fqd_pkg::INT_BCD[hi];
    frac_bcd = fqd_pkg::FRAC_BCD[lo];
    // only the most negative input keeps its sign bit after negation
    int_neg  = hi[7];
    fdig[0]  = frac_bcd[15:12];
    fdig[1]  = frac_bcd[11:8];
    fdig[2]  = frac_bcd[7:4];
    fdig[3]  = frac_bcd[3:0];
  end

  // integer text, left aligned
  always_comb begin
    if (hi >= 8'd100) begin
      ndig = 2'd3;
    end else if (hi >= 8'd10) begin
      ndig = 2'd2;
    end else begin
      ndig = 2'd1;
    end
    len = {1'b0, ndig} + {2'b00, int_neg};
    for (int i = 0; i < 4; i++) begin
      text[i] = fqd_pkg::CHAR_ZERO;
    end
    if (int_neg) begin
      text[0] = fqd_pkg::CHAR_MINUS;
      text[1] = fqd_pkg::digit_char(int_bcd[11:8]);
      text[2] = fqd_pkg::digit_char(int_bcd[7:4]);
      text[3] = fqd_pkg::digit_char(int_bcd[3:0]);
    end else begin
      case (ndig)
        2'd3: begin
          text[0] = fqd_pkg::digit_char(int_bcd[11:8]);
          text[1] = fqd_pkg::digit_char(int_bcd[7:4]);
          text[2] = fqd_pkg::digit_char(int_bcd[3:0]);
        end
        2'd2: begin
          text[0] = fqd_pkg::digit_char(int_bcd[7:4]);
          text[1] = fqd_pkg::digit_char(int_bcd[3:0]);
        end
        default: begin
          text[0] = fqd_pkg::digit_char(int_bcd[3:0]);
        end
      endcase
    end
  end

  // field geometry from the configuration
  always_comb begin
    iw_ext = CW'(int_width_i);
    if (iw_ext > CW'(MAX_INT_WIDTH)) begin
      w = POS_W'(MAX_INT_WIDTH);
    end else begin
      w = POS_W'(iw_ext);
    end
    if (POS_W'(len) < w) begin
      n = len;
    end else begin
      n = w[2:0];
    end
    if (frac_digits_i == 3'd0) begin
      fd = 3'd1;
    end else if (frac_digits_i > 3'd4) begin
      fd = 3'd4;
    end else begin
      fd = frac_digits_i;
    end
    base = w - POS_W'(n);
    // a sign in front of integer text that is not cut takes its own position
    lead = neg && (w > POS_W'(n));
  end

  // one entry per cell, in ascending position order
  always_comb begin
    for (int e = 0; e < int'(fqd_pkg::NUM_CELLS); e++) begin : g_ent
      logic [3:0] ev;
      logic [3:0] k;
      logic [3:0] j;
      ev = 4'(e);
      k  = ev - {3'b000, lead};
      j  = k - {1'b0, n} - 4'd1;
      if (lead && (ev == 4'd0)) begin
        pos_o[e]       = '0;
        chr_o[e].valid = 1'b1;
        chr_o[e].last  = 1'b0;
        chr_o[e].code  = fqd_pkg::CHAR_MINUS;
      end else begin
        pos_o[e]       = base + POS_W'(k);
        chr_o[e].valid = k < ({1'b0, n} + {1'b0, fd} + 4'd1);
        chr_o[e].last  = k == ({1'b0, n} + {1'b0, fd});
        if (k < {1'b0, n}) begin
          chr_o[e].code = text[k[1:0]];
        end else if (k == {1'b0, n}) begin
          chr_o[e].code = fqd_pkg::CHAR_DOT;
        end else begin
          chr_o[e].code = fqd_pkg::digit_char(fdig[j[1:0]]);
        end
        // the sign overwrites whatever lands on the first position
        if (neg && (pos_o[e] == '0)) begin
          chr_o[e].code = fqd_pkg::CHAR_MINUS;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/fqd_cell.sv
// ----------------------------------------------------------------------------
// fqd_cell
// One character cell of the output chain: loads a fresh entry or takes the
// entry of the cell behind it, so the chain drains one character a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_cell #(
  parameter int unsigned POS_W = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [POS_W-1:0]   load_pos_i,
  input  fqd_pkg::chr_t      load_chr_i,
  input  logic [POS_W-1:0]   next_pos_i,
  input  fqd_pkg::chr_t      next_chr_i,
  output logic [POS_W-1:0]   pos_o,
  output fqd_pkg::chr_t      chr_o
);

  logic [POS_W-1:0] pos_d, pos_q;
  fqd_pkg::chr_t    chr_d, chr_q;

  // load or shift
  always_comb begin
    if (load_i) begin
      pos_d = load_pos_i;
      chr_d = load_chr_i;
    end else begin
      pos_d = next_pos_i;
      chr_d = next_chr_i;
    end
  end

  // character and valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_q <= fqd_pkg::CHR_EMPTY;
    end else begin
      chr_q <= chr_d;
    end
  end

  // position payload
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign pos_o = pos_q;
  assign chr_o = chr_q;

endmodule

`default_nettype wire

// File: src/fixed_q8_8_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// fixed_q8_8_to_decimal_ascii_unit
// Formats a signed 8.8 fixed-point value as decimal text for a display field
// and emits one written position and its character per cycle.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------
//  request   | start, busy             | fixed_value_i
//  result    | strobe_o (no stall)     | position_o, character_o, last_char_o
//  config    | cfg_we_i, cfg_index_i   | cfg_wdata_i
//
//  A request becomes 2 to 10 results, one per cycle from the head of a
//  ten-cell character chain, starting the cycle after it is taken.
//  The next request is taken in the cycle that shows the last result of the
//  one before, so results flow without gaps; the chain drain sets the rate.
//  Reset empties the chain and sets int_width to 4 and frac_digits to 2.
//  The result side cannot stall; results are shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_q8_8_to_decimal_ascii_unit #(
  parameter int unsigned MAX_INT_WIDTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [15:0]                    fixed_value_i,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_index_i,
  input  logic [3:0]                            cfg_wdata_i,
  output logic                                  strobe_o,
  output logic [$clog2(MAX_INT_WIDTH + 5)-1:0]  position_o,
  output logic [6:0]                            character_o,
  output logic                                  last_char_o
);

  localparam int unsigned POS_W = $clog2(MAX_INT_WIDTH + 5);
  localparam int unsigned NC    = fqd_pkg::NUM_CELLS;

  logic [3:0]       int_width_q;
  logic [2:0]       frac_digits_q;
  logic             accept;
  logic [POS_W-1:0] lay_pos  [NC];
  fqd_pkg::chr_t    lay_chr  [NC];
  logic [POS_W-1:0] cell_pos [NC];
  fqd_pkg::chr_t    cell_chr [NC];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_width_q   <= fqd_pkg::INT_WIDTH_RST;
      frac_digits_q <= fqd_pkg::FRAC_DIGITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fqd_pkg::REG_INT_WIDTH:   int_width_q   <= cfg_wdata_i;
        fqd_pkg::REG_FRAC_DIGITS: frac_digits_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // request taken once at most the head character is left
  assign busy   = cell_chr[1].valid;
  assign accept = start && !busy;

  // layout of the incoming value
  fqd_layout #(
    .MAX_INT_WIDTH (MAX_INT_WIDTH),
    .POS_W         (POS_W)
  ) u_layout (
    .fixed_value_i (fixed_value_i),
    .int_width_i   (int_width_q),
    .frac_digits_i (frac_digits_q),
    .pos_o         (lay_pos),
    .chr_o         (lay_chr)
  );

  // character chain, draining towards cell zero
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic [POS_W-1:0] nxt_pos;
    fqd_pkg::chr_t    nxt_chr;
    if (i == NC - 1) begin : g_tail
      assign nxt_pos = '0;
      assign nxt_chr = fqd_pkg::CHR_EMPTY;
    end else begin : g_mid
      assign nxt_pos = cell_pos[i+1];
      assign nxt_chr = cell_chr[i+1];
    end
    fqd_cell #(
      .POS_W (POS_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (accept),
      .load_pos_i (lay_pos[i]),
      .load_chr_i (lay_chr[i]),
      .next_pos_i (nxt_pos),
      .next_chr_i (nxt_chr),
      .pos_o      (cell_pos[i]),
      .chr_o      (cell_chr[i])
    );
  end

  // head cell drives the result
  assign strobe_o    = cell_chr[0].valid;
  assign position_o  = cell_pos[0];
  assign character_o = cell_chr[0].code;
  assign last_char_o = cell_chr[0].valid && cell_chr[0].last;

endmodule

`default_nettype wire

// File: src/fqd_checker.sv
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks for the decimal text unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_checker #(
  parameter int unsigned MAX_INT_WIDTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  strobe_o,
  input  logic [$clog2(MAX_INT_WIDTH + 5)-1:0]  position_o,
  input  logic                                  last_char_o
);

  // every request gives at least a dot and one digit, starting next cycle
  a_first_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (strobe_o && !last_char_o))
    else $error("request not followed by a first result");

  // results of one request come out without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_char_o) |=> strobe_o)
    else $error("gap inside a result sequence");

  // positions rise within one request
  a_rising_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_char_o) |=> (position_o > $past(position_o)))
    else $error("positions not ascending");

  // busy only while results are still pending
  a_busy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (strobe_o && !last_char_o))
    else $error("busy without pending results");

endmodule

bind fixed_q8_8_to_decimal_ascii_unit fqd_checker #(
  .MAX_INT_WIDTH (MAX_INT_WIDTH)
) u_fqd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .strobe_o    (strobe_o),
  .position_o  (position_o),
  .last_char_o (last_char_o)
);

`default_nettype wire
